FILE: design/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types, codes and constants of the ticket cache.
// ----------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

    // Default sizes for the top-level parameters.
    localparam int SLOTS_DEF        = 8;
    localparam int KEY_BYTES_DEF    = 64;
    localparam int TICKET_BYTES_DEF = 256;

    // Command codes.
    localparam logic [2:0] CMD_KEY_BYTE    = 3'd0;
    localparam logic [2:0] CMD_TICKET_BYTE = 3'd1;
    localparam logic [2:0] CMD_PUT         = 3'd2;
    localparam logic [2:0] CMD_GET         = 3'd3;
    localparam logic [2:0] CMD_READ        = 3'd4;
    localparam logic [2:0] CMD_CLEAR       = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_MISS   = 2'd2;
    localparam logic [1:0] ST_SMALL  = 2'd3;

    // Misc constants.
    localparam logic [31:0] STAMP_MAX    = 32'hffff_ffff;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0]  CASE_OFFSET  = 8'h20;
    localparam logic [8:0]  CAP_UNLIMITED = 9'd256;

    // One input item.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data_byte;
        logic [15:0] cipher_in;
        logic        tls13_in;
        logic [8:0]  capacity;
        logic [7:0]  byte_index;
    } ltc_in_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  ticket_length;
        logic [15:0] cipher_out;
        logic        tls13_out;
        logic [7:0]  data_out;
        logic [3:0]  used_count;
    } ltc_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic stage_key;
        logic stage_ticket;
        logic clear_all;
        logic set_reject;
        logic scan_start;
        logic slot_inc;
        logic cmp_read;
        logic j_inc;
        logic mark_match;
        logic take_free;
        logic old_start;
        logic old_step;
        logic take_old;
        logic copy_start;
        logic copy_step;
        logic put_commit;
        logic get_commit;
        logic read_issue;
        logic read_finish;
        logic emit;
    } ltc_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        logic       key_empty;
        logic       put_bad;
        logic       slot_eligible;
        logic       slot_last;
        logic       byte_eq;
        logic       byte_last;
        logic       match;
        logic       any_free;
        logic       old_found;
        logic       copy_last;
        logic       read_ok;
    } ltc_sts_t;

endpackage

`default_nettype wire

FILE: design/ltc_ram.sv
// ----------------------------------------------------------------------------
// ltc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/ltc_datapath.sv
// ----------------------------------------------------------------------------
// ltc_datapath
// Staging buffers, entry storage, slot metadata and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_datapath
    import ltc_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int KEY_BYTES    = KEY_BYTES_DEF,
    parameter int TICKET_BYTES = TICKET_BYTES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ltc_in_t  item,
    input  wire ltc_ctl_t ctl,
    output ltc_sts_t      sts,
    output logic          done,
    output ltc_out_t      result
);

    localparam int KC     = KEY_BYTES - 1;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KCW    = $clog2(KC + 1);
    localparam int TCW    = $clog2(TICKET_BYTES + 1);
    localparam int UCW    = $clog2(SLOTS + 1);
    localparam int COPY_N = (TICKET_BYTES > KC) ? TICKET_BYTES : KC;
    localparam int JW     = (COPY_N > 1) ? $clog2(COPY_N) : 1;
    localparam int SKA    = (KC > 1) ? $clog2(KC) : 1;
    localparam int STA    = (TICKET_BYTES > 1) ? $clog2(TICKET_BYTES) : 1;
    localparam int EKD    = SLOTS * KC;
    localparam int EKA    = (EKD > 1) ? $clog2(EKD) : 1;
    localparam int ETD    = SLOTS * TICKET_BYTES;
    localparam int ETA    = (ETD > 1) ? $clog2(ETD) : 1;

    ltc_in_t          item_reg;
    logic [KCW-1:0]   key_cnt_reg;
    logic             key_end_reg;
    logic [TCW-1:0]   tkt_cnt_reg;
    logic             ovf_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [KCW-1:0]   key_len_reg [SLOTS];
    logic [TCW-1:0]   tkt_len_reg [SLOTS];
    logic [31:0]      stamp_reg [SLOTS];
    logic [15:0]      cipher_reg [SLOTS];
    logic [SLOTS-1:0] ver_reg;
    logic [31:0]      stamp_ctr_reg;
    logic [SW-1:0]    hit_slot_reg;
    logic             hit_valid_reg;
    logic [SW-1:0]    slot_reg;
    logic [JW-1:0]    j_reg;
    logic [31:0]      min_reg;
    logic [SW-1:0]    min_slot_reg;
    logic             min_found_reg;
    logic             match_reg;
    logic [1:0]       res_status_reg;
    logic [8:0]       res_tlen_reg;
    logic [15:0]      res_cipher_reg;
    logic             res_ver_reg;
    logic [7:0]       res_data_reg;
    ltc_out_t         out_reg;
    logic             done_reg;
    logic             wr_valid_reg;
    logic             wr_key_reg;
    logic             wr_tkt_reg;
    logic             wr_live_reg;
    logic [JW-1:0]    wr_j_reg;

    logic [31:0]    stamp_inc;
    logic [7:0]     folded;
    logic [SW-1:0]  free_slot;
    logic [UCW-1:0] used_cnt;
    logic           small_buf;
    logic           sk_we, st_we;
    logic [7:0]     sk_rdata, st_rdata, ek_rdata, et_rdata;
    logic [EKA-1:0] ek_waddr, ek_raddr;
    logic [ETA-1:0] et_waddr, et_raddr;

    assign stamp_inc = stamp_ctr_reg + 32'd1;

    // Upper-case letters fold to lower case.
    assign folded = (item_reg.data_byte >= CHAR_UPPER_A && item_reg.data_byte <= CHAR_UPPER_Z)
                    ? item_reg.data_byte + CASE_OFFSET : item_reg.data_byte;

    // First free slot and the occupancy count.
    always_comb
    begin
        free_slot = '0;
        used_cnt  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            used_cnt = used_cnt + UCW'(valid_reg[i]);
        end
    end

    // The caller buffer is too small when below both the limit and the length.
    assign small_buf = !item_reg.capacity[8] &&
                       (int'(item_reg.capacity) < int'(tkt_len_reg[slot_reg]));

    // Storage write enables and addresses.
    assign sk_we = ctl.stage_key && !key_end_reg && (item_reg.data_byte != 8'd0) &&
                   (int'(key_cnt_reg) < KC);
    assign st_we = ctl.stage_ticket && !ovf_reg && (int'(tkt_cnt_reg) < TICKET_BYTES);
    assign ek_waddr = EKA'(int'(slot_reg) * KC + int'(wr_j_reg));
    assign ek_raddr = EKA'(int'(slot_reg) * KC + int'(j_reg));
    assign et_waddr = ETA'(int'(slot_reg) * TICKET_BYTES + int'(wr_j_reg));
    assign et_raddr = ETA'(int'(hit_slot_reg) * TICKET_BYTES + int'(item_reg.byte_index));

    ltc_ram #(.WIDTH(8), .DEPTH(KC)) u_staged_key (
        .clk   (clk),
        .we    (sk_we),
        .waddr (key_cnt_reg[SKA-1:0]),
        .wdata (folded),
        .re    (ctl.cmp_read | ctl.copy_step),
        .raddr (j_reg[SKA-1:0]),
        .rdata (sk_rdata)
    );

    ltc_ram #(.WIDTH(8), .DEPTH(TICKET_BYTES)) u_staged_ticket (
        .clk   (clk),
        .we    (st_we),
        .waddr (tkt_cnt_reg[STA-1:0]),
        .wdata (item_reg.data_byte),
        .re    (ctl.copy_step),
        .raddr (j_reg[STA-1:0]),
        .rdata (st_rdata)
    );

    ltc_ram #(.WIDTH(8), .DEPTH(EKD)) u_entry_key (
        .clk   (clk),
        .we    (wr_valid_reg && wr_key_reg),
        .waddr (ek_waddr),
        .wdata (sk_rdata),
        .re    (ctl.cmp_read),
        .raddr (ek_raddr),
        .rdata (ek_rdata)
    );

    ltc_ram #(.WIDTH(8), .DEPTH(ETD)) u_entry_ticket (
        .clk   (clk),
        .we    (wr_valid_reg && wr_tkt_reg),
        .waddr (et_waddr),
        .wdata (wr_live_reg ? st_rdata : 8'd0),
        .re    (ctl.read_issue),
        .raddr (et_raddr),
        .rdata (et_rdata)
    );

    // Status toward the controller.
    always_comb
    begin
        sts.cmd           = item_reg.cmd;
        sts.key_empty     = (key_cnt_reg == '0);
        sts.put_bad       = (key_cnt_reg == '0) || (tkt_cnt_reg == '0) || ovf_reg;
        sts.slot_eligible = valid_reg[slot_reg] && (key_len_reg[slot_reg] == key_cnt_reg);
        sts.slot_last     = (int'(slot_reg) == SLOTS - 1);
        sts.byte_eq       = (ek_rdata == sk_rdata);
        sts.byte_last     = (int'(j_reg) + 1 == int'(key_cnt_reg));
        sts.match         = match_reg;
        sts.any_free      = !(&valid_reg);
        sts.old_found     = min_found_reg;
        sts.copy_last     = (int'(j_reg) == COPY_N - 1);
        sts.read_ok       = hit_valid_reg && (int'(item_reg.byte_index) < TICKET_BYTES);
    end

    // Control state: staging, valid bits, stamps and the last hit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cnt_reg   <= '0;
            key_end_reg   <= 1'b0;
            tkt_cnt_reg   <= '0;
            ovf_reg       <= 1'b0;
            valid_reg     <= '0;
            stamp_ctr_reg <= '0;
            hit_slot_reg  <= '0;
            hit_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
            min_found_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            wr_valid_reg <= ctl.copy_step;
            done_reg     <= ctl.emit;
            if (ctl.stage_key && !key_end_reg)
            begin
                if (item_reg.data_byte == 8'd0)
                begin
                    key_end_reg <= 1'b1;
                end
                else if (int'(key_cnt_reg) < KC)
                begin
                    key_cnt_reg <= key_cnt_reg + KCW'(1);
                end
            end
            if (ctl.stage_ticket)
            begin
                if (ovf_reg || int'(tkt_cnt_reg) >= TICKET_BYTES)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    tkt_cnt_reg <= tkt_cnt_reg + TCW'(1);
                end
            end
            if (ctl.scan_start)
            begin
                match_reg <= 1'b0;
            end
            if (ctl.mark_match)
            begin
                match_reg <= 1'b1;
            end
            if (ctl.old_start)
            begin
                min_found_reg <= 1'b0;
            end
            if (ctl.old_step && stamp_reg[slot_reg] < min_reg)
            begin
                min_found_reg <= 1'b1;
            end
            if (ctl.put_commit)
            begin
                valid_reg[slot_reg] <= 1'b1;
                stamp_ctr_reg       <= stamp_inc;
                stamp_reg[slot_reg] <= stamp_inc;
            end
            if (ctl.get_commit)
            begin
                hit_valid_reg <= 1'b0;
                if (match_reg && !small_buf)
                begin
                    stamp_ctr_reg       <= stamp_inc;
                    stamp_reg[slot_reg] <= stamp_inc;
                    hit_slot_reg        <= slot_reg;
                    hit_valid_reg       <= 1'b1;
                end
            end
            if (ctl.clear_all)
            begin
                valid_reg     <= '0;
                stamp_ctr_reg <= '0;
                hit_valid_reg <= 1'b0;
            end
            // Put and get consume the staging whatever their outcome.
            if (ctl.clear_all || ctl.put_commit || ctl.get_commit ||
                (ctl.set_reject && item_reg.cmd == CMD_PUT))
            begin
                key_cnt_reg <= '0;
                key_end_reg <= 1'b0;
                tkt_cnt_reg <= '0;
                ovf_reg     <= 1'b0;
            end
        end
    end

    // Payload: item, scan counters, metadata and result fields.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg       <= item;
            res_status_reg <= ST_OK;
            res_tlen_reg   <= '0;
            res_cipher_reg <= '0;
            res_ver_reg    <= 1'b0;
            res_data_reg   <= '0;
        end
        if (ctl.stage_ticket && (ovf_reg || int'(tkt_cnt_reg) >= TICKET_BYTES))
        begin
            res_status_reg <= ST_REJECT;
        end
        if (ctl.set_reject)
        begin
            res_status_reg <= ST_REJECT;
        end
        if (ctl.scan_start)
        begin
            slot_reg <= '0;
            j_reg    <= '0;
        end
        if (ctl.slot_inc)
        begin
            slot_reg <= slot_reg + SW'(1);
            j_reg    <= '0;
        end
        if (ctl.j_inc)
        begin
            j_reg <= j_reg + JW'(1);
        end
        if (ctl.take_free)
        begin
            slot_reg <= free_slot;
        end
        if (ctl.old_start)
        begin
            slot_reg <= '0;
            min_reg  <= STAMP_MAX;
        end
        if (ctl.old_step)
        begin
            if (stamp_reg[slot_reg] < min_reg)
            begin
                min_reg      <= stamp_reg[slot_reg];
                min_slot_reg <= slot_reg;
            end
            if (int'(slot_reg) != SLOTS - 1)
            begin
                slot_reg <= slot_reg + SW'(1);
            end
        end
        if (ctl.take_old)
        begin
            slot_reg <= min_slot_reg;
        end
        if (ctl.copy_start)
        begin
            j_reg <= '0;
        end
        // Copy runs one byte a cycle; the write lands in the cycle after its read.
        if (ctl.copy_step)
        begin
            wr_j_reg    <= j_reg;
            wr_key_reg  <= (int'(j_reg) < int'(key_cnt_reg));
            wr_tkt_reg  <= (int'(j_reg) < TICKET_BYTES);
            wr_live_reg <= (int'(j_reg) < int'(tkt_cnt_reg));
            if (int'(j_reg) != COPY_N - 1)
            begin
                j_reg <= j_reg + JW'(1);
            end
        end
        if (ctl.put_commit)
        begin
            key_len_reg[slot_reg] <= key_cnt_reg;
            tkt_len_reg[slot_reg] <= tkt_cnt_reg;
            cipher_reg[slot_reg]  <= item_reg.cipher_in;
            ver_reg[slot_reg]     <= item_reg.tls13_in;
        end
        if (ctl.get_commit)
        begin
            if (!match_reg)
            begin
                res_status_reg <= ST_MISS;
            end
            else if (small_buf)
            begin
                res_status_reg <= ST_SMALL;
            end
            else
            begin
                res_tlen_reg   <= 9'(tkt_len_reg[slot_reg]);
                res_cipher_reg <= cipher_reg[slot_reg];
                res_ver_reg    <= ver_reg[slot_reg];
            end
        end
        if (ctl.read_finish)
        begin
            if (!hit_valid_reg)
            begin
                res_status_reg <= ST_MISS;
            end
            else if (int'(item_reg.byte_index) < TICKET_BYTES)
            begin
                res_data_reg <= et_rdata;
            end
        end
        if (ctl.emit)
        begin
            out_reg.status        <= res_status_reg;
            out_reg.ticket_length <= res_tlen_reg;
            out_reg.cipher_out    <= res_cipher_reg;
            out_reg.tls13_out     <= res_ver_reg;
            out_reg.data_out      <= res_data_reg;
            out_reg.used_count    <= 4'(used_cnt);
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

FILE: design/ltc_ctrl.sv
// ----------------------------------------------------------------------------
// ltc_ctrl
// Sequencer of the ticket cache: dispatch, key scan, eviction and copy.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_ctrl
    import ltc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ltc_sts_t sts,
    output ltc_ctl_t      ctl,
    output logic          busy
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DISP   = 13'b0000000000010,
        S_MSEL   = 13'b0000000000100,
        S_MRD    = 13'b0000000001000,
        S_MCHK   = 13'b0000000010000,
        S_MDONE  = 13'b0000000100000,
        S_OLD    = 13'b0000001000000,
        S_OLDEND = 13'b0000010000000,
        S_COPY   = 13'b0000100000000,
        S_DRAIN  = 13'b0001000000000,
        S_GETFIN = 13'b0010000000000,
        S_RDWAIT = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } ltc_state_t;

    ltc_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.cmd)
                    CMD_KEY_BYTE:
                    begin
                        ctl.stage_key = 1'b1;
                        state_next    = S_FIN;
                    end
                    CMD_TICKET_BYTE:
                    begin
                        ctl.stage_ticket = 1'b1;
                        state_next       = S_FIN;
                    end
                    CMD_PUT:
                    begin
                        if (sts.put_bad)
                        begin
                            ctl.set_reject = 1'b1;
                            state_next     = S_FIN;
                        end
                        else
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_MSEL;
                        end
                    end
                    CMD_GET:
                    begin
                        ctl.scan_start = 1'b1;
                        state_next     = sts.key_empty ? S_GETFIN : S_MSEL;
                    end
                    CMD_READ:
                    begin
                        if (sts.read_ok)
                        begin
                            ctl.read_issue = 1'b1;
                            state_next     = S_RDWAIT;
                        end
                        else
                        begin
                            ctl.read_finish = 1'b1;
                            state_next      = S_FIN;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ctl.clear_all = 1'b1;
                        state_next    = S_FIN;
                    end
                    default:
                    begin
                        ctl.set_reject = 1'b1;
                        state_next     = S_FIN;
                    end
                endcase
            end
            // Walk the slots for one whose key length matches.
            S_MSEL:
            begin
                if (sts.slot_eligible)
                begin
                    state_next = S_MRD;
                end
                else if (sts.slot_last)
                begin
                    state_next = S_MDONE;
                end
                else
                begin
                    ctl.slot_inc = 1'b1;
                end
            end
            S_MRD:
            begin
                ctl.cmp_read = 1'b1;
                state_next   = S_MCHK;
            end
            // Compare one key byte of the candidate slot.
            S_MCHK:
            begin
                if (!sts.byte_eq)
                begin
                    if (sts.slot_last)
                    begin
                        state_next = S_MDONE;
                    end
                    else
                    begin
                        ctl.slot_inc = 1'b1;
                        state_next   = S_MSEL;
                    end
                end
                else if (sts.byte_last)
                begin
                    ctl.mark_match = 1'b1;
                    state_next     = S_MDONE;
                end
                else
                begin
                    ctl.j_inc  = 1'b1;
                    state_next = S_MRD;
                end
            end
            // Finish a get, or pick the slot a put writes to.
            S_MDONE:
            begin
                if (sts.cmd == CMD_GET)
                begin
                    state_next = S_GETFIN;
                end
                else if (sts.match)
                begin
                    ctl.copy_start = 1'b1;
                    state_next     = S_COPY;
                end
                else if (sts.any_free)
                begin
                    ctl.take_free  = 1'b1;
                    ctl.copy_start = 1'b1;
                    state_next     = S_COPY;
                end
                else
                begin
                    ctl.old_start = 1'b1;
                    state_next    = S_OLD;
                end
            end
            S_OLD:
            begin
                ctl.old_step = 1'b1;
                if (sts.slot_last)
                begin
                    state_next = S_OLDEND;
                end
            end
            S_OLDEND:
            begin
                if (sts.old_found)
                begin
                    ctl.take_old   = 1'b1;
                    ctl.copy_start = 1'b1;
                    state_next     = S_COPY;
                end
                else
                begin
                    ctl.set_reject = 1'b1;
                    state_next     = S_FIN;
                end
            end
            S_COPY:
            begin
                ctl.copy_step = 1'b1;
                if (sts.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                ctl.put_commit = 1'b1;
                state_next     = S_FIN;
            end
            S_GETFIN:
            begin
                ctl.get_commit = 1'b1;
                state_next     = S_FIN;
            end
            S_RDWAIT:
            begin
                ctl.read_finish = 1'b1;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                ctl.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

FILE: design/lru_ticket_cache.sv
// ----------------------------------------------------------------------------
// lru_ticket_cache
// Session ticket cache with lower-case name keys and least-recent eviction.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low, and exactly one
// result follows on the result port with done high for one cycle; the
// receiver cannot stall it. Key byte, ticket byte, read, clear and rejected
// items pass through dispatch and a final state before the registered
// result strobe (a read that fetches a stored byte also waits in S_RDWAIT),
// and the next item can be started in the strobe cycle. Put and get run a
// slot scan that reads each key byte from the entry key memory in S_MRD and
// compares it in S_MCHK. A put walks every slot for the oldest stamp when it
// must evict, and then copies max(TICKET_BYTES, KEY_BYTES - 1) bytes through
// a one-byte-per-cycle port of the entry memories. No clearing pass runs
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_ticket_cache
    import ltc_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int KEY_BYTES    = KEY_BYTES_DEF,
    parameter int TICKET_BYTES = TICKET_BYTES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire ltc_in_t item,
    output logic         done,
    output ltc_out_t     result
);

    ltc_ctl_t ctl;
    ltc_sts_t sts;

    // Sequencer.
    ltc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Storage and result registers.
    ltc_datapath #(
        .SLOTS        (SLOTS),
        .KEY_BYTES    (KEY_BYTES),
        .TICKET_BYTES (TICKET_BYTES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctl    (ctl),
        .sts    (sts),
        .done   (done),
        .result (result)
    );

    // A result is only shown while the block is free for the next item.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // Each item gives one strobe, never two in a row.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

FILE: dv/lru_ticket_cache_checker.sv
// ----------------------------------------------------------------------------
// lru_ticket_cache_checker
// Watches the command and result ports of the ticket cache, keeps its own
// model of the entries and staging, and compares every result with the
// expected one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_ticket_cache_checker
    import ltc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  ltc_in_t  item,
    input  logic     done,
    input  ltc_out_t result,
    output int       fail_count,
    output int       pending_count,
    output logic     item_taken
);

    localparam int NSLOT = SLOTS_DEF;
    localparam int KCHARS = KEY_BYTES_DEF - 1;
    localparam int TBYTES = TICKET_BYTES_DEF;

    // Model state of the cache.
    logic [7:0]  slot_key [NSLOT][KCHARS];
    int          slot_key_len [NSLOT];
    logic [7:0]  slot_ticket [NSLOT][TBYTES];
    int          slot_ticket_len [NSLOT];
    logic [31:0] slot_stamp [NSLOT];
    logic [15:0] slot_cipher [NSLOT];
    logic        slot_tls13 [NSLOT];
    logic        slot_live [NSLOT];
    logic [31:0] stamp_now;
    logic [7:0]  key_buf [KCHARS];
    int          key_cnt;
    logic        key_closed;
    logic [7:0]  ticket_buf [TBYTES];
    int          ticket_cnt;
    logic        ticket_over;
    int          last_hit;
    logic        last_hit_ok;

    ltc_out_t expected_results [$];

    assign pending_count = expected_results.size();
    assign item_taken = start && !busy;

    function automatic int lookup_key();
        logic same;
        for (int s = 0; s < NSLOT; s++) begin
            if (slot_live[s] && slot_key_len[s] == key_cnt) begin
                same = 1'b1;
                for (int j = 0; j < key_cnt; j++)
                    if (slot_key[s][j] != key_buf[j])
                        same = 1'b0;
                if (same)
                    return s;
            end
        end
        return -1;
    endfunction

    function automatic void reset_staging();
        key_cnt = 0;
        key_closed = 1'b0;
        ticket_cnt = 0;
        ticket_over = 1'b0;
    endfunction

    function automatic void reset_cache();
        for (int s = 0; s < NSLOT; s++) begin
            slot_live[s] = 1'b0;
            slot_stamp[s] = '0;
            slot_key_len[s] = 0;
            slot_ticket_len[s] = 0;
        end
        stamp_now = '0;
        last_hit = 0;
        last_hit_ok = 1'b0;
        reset_staging();
    endfunction

    // Works out the result of one accepted item and updates the model.
    function automatic ltc_out_t predict_cache_item(ltc_in_t it);
        ltc_out_t r;
        logic [7:0]  b;
        logic [31:0] oldest;
        int s;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_KEY_BYTE:
            begin
                b = it.data_byte;
                if (!key_closed) begin
                    if (b == 8'd0)
                        key_closed = 1'b1;
                    else if (key_cnt < KCHARS) begin
                        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
                            b = b + CASE_OFFSET;
                        key_buf[key_cnt] = b;
                        key_cnt++;
                    end
                end
            end
            CMD_TICKET_BYTE:
            begin
                if (ticket_over || ticket_cnt >= TBYTES) begin
                    ticket_over = 1'b1;
                    r.status = ST_REJECT;
                end else begin
                    ticket_buf[ticket_cnt] = it.data_byte;
                    ticket_cnt++;
                end
            end
            CMD_PUT:
            begin
                if (key_cnt == 0 || ticket_cnt == 0 || ticket_over)
                    r.status = ST_REJECT;
                else begin
                    s = lookup_key();
                    if (s < 0)
                        for (int i = 0; i < NSLOT; i++)
                            if (!slot_live[i] && s < 0)
                                s = i;
                    if (s < 0) begin
                        oldest = STAMP_MAX;
                        for (int i = 0; i < NSLOT; i++)
                            if (slot_stamp[i] < oldest) begin
                                oldest = slot_stamp[i];
                                s = i;
                            end
                    end
                    if (s < 0)
                        r.status = ST_REJECT;
                    else begin
                        for (int j = 0; j < key_cnt; j++)
                            slot_key[s][j] = key_buf[j];
                        slot_key_len[s] = key_cnt;
                        for (int j = 0; j < TBYTES; j++)
                            slot_ticket[s][j] = (j < ticket_cnt) ? ticket_buf[j] : 8'd0;
                        slot_ticket_len[s] = ticket_cnt;
                        stamp_now = stamp_now + 32'd1;
                        slot_stamp[s] = stamp_now;
                        slot_cipher[s] = it.cipher_in;
                        slot_tls13[s] = it.tls13_in;
                        slot_live[s] = 1'b1;
                    end
                end
                reset_staging();
            end
            CMD_GET:
            begin
                s = (key_cnt == 0) ? -1 : lookup_key();
                last_hit_ok = 1'b0;
                if (s < 0)
                    r.status = ST_MISS;
                else if (it.capacity < CAP_UNLIMITED && it.capacity < slot_ticket_len[s])
                    r.status = ST_SMALL;
                else begin
                    r.ticket_length = 9'(slot_ticket_len[s]);
                    r.cipher_out = slot_cipher[s];
                    r.tls13_out = slot_tls13[s];
                    stamp_now = stamp_now + 32'd1;
                    slot_stamp[s] = stamp_now;
                    last_hit = s;
                    last_hit_ok = 1'b1;
                end
                reset_staging();
            end
            CMD_READ:
            begin
                if (!last_hit_ok)
                    r.status = ST_MISS;
                else
                    r.data_out = slot_ticket[last_hit][it.byte_index];
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < NSLOT; i++) begin
                    for (int j = 0; j < TBYTES; j++)
                        slot_ticket[i][j] = 8'd0;
                    slot_live[i] = 1'b0;
                    slot_ticket_len[i] = 0;
                    slot_key_len[i] = 0;
                end
                stamp_now = '0;
                last_hit_ok = 1'b0;
                reset_staging();
            end
            default:
                r.status = ST_REJECT;
        endcase
        for (int i = 0; i < NSLOT; i++)
            if (slot_live[i])
                r.used_count++;
        return r;
    endfunction

    // Predict on acceptance, compare on each result strobe.
    always @(posedge clk or negedge rst_n)
    begin
        ltc_out_t want;
        if (!rst_n) begin
            reset_cache();
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result %h", result);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (result !== want) begin
                        if (fail_count < 10)
                            $display("ERROR: result mismatch: expected st=%0d len=%0d ciph=%h v=%0d d=%h used=%0d, got st=%0d len=%0d ciph=%h v=%0d d=%h used=%0d",
                                want.status, want.ticket_length, want.cipher_out,
                                want.tls13_out, want.data_out, want.used_count,
                                result.status, result.ticket_length, result.cipher_out,
                                result.tls13_out, result.data_out, result.used_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_cache_item(item));
        end
    end

endmodule

FILE: dv/lru_ticket_cache_test.sv
// ----------------------------------------------------------------------------
// lru_ticket_cache_test
// Drives directed and random command sequences into the ticket cache, with
// random idle gaps, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_ticket_cache_test;
    import ltc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    // Command codes the block does not implement.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ltc_in_t  item;
    logic     done;
    ltc_out_t result;
    int       fail_count;
    int       pending_count;
    logic     item_taken;
    int       idle_cycles;
    int       idle_pct;

    lru_ticket_cache dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    lru_ticket_cache_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .item_taken    (item_taken)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: ends the run when nothing is accepted or completed for too long.
    always @(posedge clk)
    begin
        if (item_taken || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // A fully random item.
    function automatic ltc_in_t rand_item();
        ltc_in_t it;
        it.cmd        = 3'($urandom);
        it.data_byte  = 8'($urandom);
        it.cipher_in  = 16'($urandom);
        it.tls13_in   = 1'($urandom);
        it.capacity   = 9'($urandom);
        it.byte_index = 8'($urandom);
        return it;
    endfunction

    // Sends one item, with a random gap before it, and waits for acceptance.
    // Start stays high after acceptance until the next item or an idle cycle.
    task automatic send_item(input ltc_in_t it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_cmd(input logic [2:0] c, input logic [7:0] b);
        ltc_in_t it;
        it = rand_item();
        it.cmd = c;
        it.data_byte = b;
        it.capacity = CAP_UNLIMITED;
        send_item(it);
    endtask

    // Stages a key from a small name pool, so that puts and gets collide.
    task automatic stage_key(input int name, input int len, input logic upper);
        for (int j = 0; j < len; j++)
            send_cmd(CMD_KEY_BYTE, 8'((upper ? 8'h41 : 8'h61) + ((name + j) % 26)));
        if ($urandom_range(1))
            send_cmd(CMD_KEY_BYTE, 8'd0);
    endtask

    task automatic stage_ticket(input int len);
        for (int j = 0; j < len; j++)
            send_cmd(CMD_TICKET_BYTE, 8'($urandom));
    endtask

    task automatic do_get(input logic [8:0] cap);
        ltc_in_t it;
        it = rand_item();
        it.cmd = CMD_GET;
        it.capacity = cap;
        send_item(it);
    endtask

    task automatic do_read(input logic [7:0] idx);
        ltc_in_t it;
        it = rand_item();
        it.cmd = CMD_READ;
        it.byte_index = idx;
        send_item(it);
    endtask

    initial
    begin
        ltc_in_t it;
        int n;
        int sel;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        idle_cycles = 0;
        idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: read without hit, empty get/put, unknown commands.
        do_read(8'd0);
        do_get(9'd0);
        send_cmd(CMD_PUT, 8'd0);
        send_cmd(CMD_UNUSED_LO, 8'hff);
        send_cmd(CMD_UNUSED_HI, 8'h00);
        // Key with upper case, a zero end and a byte after it.
        send_cmd(CMD_KEY_BYTE, 8'h5a);
        send_cmd(CMD_KEY_BYTE, 8'h41);
        send_cmd(CMD_KEY_BYTE, 8'hff);
        send_cmd(CMD_KEY_BYTE, 8'h00);
        send_cmd(CMD_KEY_BYTE, 8'h42);
        send_cmd(CMD_TICKET_BYTE, 8'hff);
        send_cmd(CMD_TICKET_BYTE, 8'h00);
        it = '1;
        it.cmd = CMD_PUT;
        send_item(it);
        send_cmd(CMD_KEY_BYTE, 8'h7a);
        send_cmd(CMD_KEY_BYTE, 8'h61);
        send_cmd(CMD_KEY_BYTE, 8'hff);
        do_get(9'd1);
        send_cmd(CMD_KEY_BYTE, 8'h7a);
        send_cmd(CMD_KEY_BYTE, 8'h61);
        send_cmd(CMD_KEY_BYTE, 8'hff);
        do_get(9'd2);
        do_read(8'd1);
        do_read(8'hff);
        send_cmd(CMD_CLEAR, 8'd0);
        do_read(8'd0);

        // Over-long upper-case key and maximum ticket, back to back, then
        // looked up by the lower-case key and read back at its last byte.
        stage_key(3, 64, 1'b1);
        stage_ticket(256);
        send_cmd(CMD_PUT, 8'd0);
        stage_key(3, 63, 1'b0);
        do_get(9'd256);
        do_read(8'd255);

        // Random traffic over a small key pool to force hits and eviction.
        for (int k = 0; k < 30; k++) begin
            idle_pct = (k >= 10 && k < 20) ? 0 : 26;
            sel = $urandom_range(99);
            n = $urandom_range(12);
            if (sel < 40) begin
                stage_key(n, 1 + (n % 3), 1'($urandom_range(1)));
                stage_ticket($urandom_range(1, 6));
                it = rand_item();
                it.cmd = CMD_PUT;
                send_item(it);
            end else if (sel < 80) begin
                stage_key(n, 1 + (n % 3), 1'($urandom_range(1)));
                do_get(9'($urandom_range(1) ? $urandom_range(0, 6) : $urandom_range(0, 511)));
                repeat ($urandom_range(3))
                    do_read(8'($urandom_range(1) ? $urandom_range(7) : $urandom));
            end else if (sel < 85) begin
                send_cmd(CMD_CLEAR, 8'($urandom));
            end else begin
                it = rand_item();
                send_item(it);
            end
        end

        // Drain and let the last item finish.
        start <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
